// File: sv/stp_pkg.sv
// Shared command codes, status codes and fixed field widths for the software timer pool.
package stp_pkg;

  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 3;
  localparam int LIMIT_W  = 16;
  localparam int ELAPSED_W = 16;

  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESET = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET   = 3'd4;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd61000;

endpackage

// File: sv/software_timer_pool_unit.sv
// Software timer pool: shared tick counter, start marks in one memory, busy flags in flops.
//
//   channel   signals                               direction  when taken
//   command   start, busy, command, handle          in         start && !busy
//   result    done, status, granted_handle, elapsed out        done (one cycle)
//   config    cfg_write, cfg_data                   in         cfg_write
//
// Each command reads the start-mark memory in the accept cycle, and one that changes a mark
// writes it back in the next one, during which busy is high and the result is shown.
// Rebasing costs nothing extra: busy timers keep their mark offset by a running base, so
// a rebase only moves the base. Reset is synchronous; no clearing pass is needed because
// per-entry valid bits make unwritten marks read as zero. The receiver cannot stall.
module software_timer_pool_unit #(
  parameter int NUM_TIMERS = 8,
  parameter int TICK_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [stp_pkg::CMD_W-1:0]        command,
  input  logic [stp_pkg::HANDLE_W-1:0]     handle,
  input  logic                             cfg_write,
  input  logic [stp_pkg::LIMIT_W-1:0]      cfg_data,
  output logic                             done,
  output logic                             status,
  output logic [stp_pkg::HANDLE_W-1:0]     granted_handle,
  output logic [stp_pkg::ELAPSED_W-1:0]    elapsed
);
  import stp_pkg::*;

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic [0:0]           state;
  logic [LIMIT_W-1:0]   rebase_limit;
  logic [TICK_BITS-1:0] tick_count;
  logic [TICK_BITS-1:0] tick_count_next;
  logic [TICK_BITS-1:0] base;
  logic [TICK_BITS-1:0] base_next;
  logic [NUM_TIMERS-1:0] busy_flag;
  logic [NUM_TIMERS-1:0] busy_flag_next;
  logic [NUM_TIMERS-1:0] mark_valid;

  // Busy timers hold (start + base); free timers hold the start mark itself.
  logic [TICK_BITS-1:0] mark_mem [NUM_TIMERS];
  logic [TICK_BITS-1:0] rd_data;
  logic                 mem_we;
  logic [TICK_BITS-1:0] mem_wdata;

  logic [CMD_W-1:0]     cmd_q;
  logic [AW-1:0]        addr_q;
  logic                 hvalid_q;
  logic                 full_q;

  logic                 accept;
  logic [31:0]          handle_w;
  logic [AW-1:0]        handle_addr;
  logic                 handle_valid;
  logic                 free_found;
  logic [AW-1:0]        free_idx;
  logic [AW-1:0]        rd_addr;

  logic [TICK_BITS-1:0] mark_raw;
  logic                 entry_busy;
  logic [TICK_BITS-1:0] tick_inc;
  logic [TICK_BITS-1:0] diff;
  logic [31:0]          diff_w;
  logic [31:0]          grant_w;

  assign busy   = (state == S_EXEC);
  assign done   = (state == S_EXEC);
  assign accept = start && !busy;

  assign handle_w     = {{(32 - HANDLE_W){1'b0}}, handle};
  assign handle_addr  = handle_w[AW-1:0];
  assign handle_valid = (handle_w < 32'(NUM_TIMERS));

  // Lowest free timer.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!busy_flag[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  assign rd_addr = (command == CMD_ALLOC) ? free_idx : handle_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mark_mem[addr_q] <= mem_wdata;
    end
    rd_data <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= command;
      addr_q   <= rd_addr;
      hvalid_q <= handle_valid;
      full_q   <= !free_found;
    end
  end

  assign mark_raw   = mark_valid[addr_q] ? rd_data : '0;
  assign entry_busy = busy_flag[addr_q];
  assign tick_inc   = tick_count + TICK_BITS'(1);
  assign grant_w    = {{(32 - AW){1'b0}}, addr_q};

  always_comb begin
    tick_count_next = tick_count;
    base_next       = base;
    busy_flag_next  = busy_flag;
    mem_we          = 1'b0;
    mem_wdata       = '0;
    diff            = '0;
    status          = STATUS_OK;
    granted_handle  = '0;
    if (state == S_EXEC) begin
      case (cmd_q)
        CMD_TICK: begin
          if (32'(tick_inc) >= 32'(rebase_limit)) begin
            tick_count_next = '0;
            base_next       = base + tick_inc;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        CMD_ALLOC: begin
          if (full_q) begin
            status = STATUS_FULL;
          end else begin
            busy_flag_next[addr_q] = 1'b1;
            mem_we                 = 1'b1;
            mem_wdata              = mark_raw + base;
            granted_handle         = grant_w[HANDLE_W-1:0];
          end
        end
        CMD_FREE: begin
          if (hvalid_q && entry_busy) begin
            busy_flag_next[addr_q] = 1'b0;
            mem_we                 = 1'b1;
            mem_wdata              = mark_raw - base;
          end
        end
        CMD_RESET: begin
          if (hvalid_q) begin
            mem_we    = 1'b1;
            mem_wdata = entry_busy ? (tick_count + base) : tick_count;
          end
        end
        CMD_GET: begin
          if (hvalid_q) begin
            diff = entry_busy ? (tick_count + base - mark_raw) : (tick_count - mark_raw);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign diff_w  = 32'(diff);
  assign elapsed = diff_w[ELAPSED_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rebase_limit <= LIMIT_RESET;
      tick_count   <= '0;
      base         <= '0;
      busy_flag    <= '0;
      mark_valid   <= '0;
    end else begin
      if (cfg_write) begin
        rebase_limit <= cfg_data;
      end
      tick_count <= tick_count_next;
      base       <= base_next;
      busy_flag  <= busy_flag_next;
      if (mem_we) begin
        mark_valid[addr_q] <= 1'b1;
      end
      if (accept) begin
        state <= S_EXEC;
      end else begin
        state <= S_IDLE;
      end
    end
  end

  // Every accepted word yields exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted word produced no result");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results without an accepted word");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    done && (status == STATUS_FULL) |-> (granted_handle == '0) && (elapsed == '0))
    else $error("pool-full result carries data");

  a_grant_marks_busy: assert property (@(posedge clk) disable iff (rst)
    done && (cmd_q == CMD_ALLOC) && (status == STATUS_OK) |=> busy_flag[$past(addr_q)])
    else $error("granted timer not marked busy");

  a_grant_was_free: assert property (@(posedge clk) disable iff (rst)
    done && (cmd_q == CMD_ALLOC) && (status == STATUS_OK) |-> !busy_flag[addr_q])
    else $error("granted timer was already busy");

endmodule

// File: dv/tb_software_timer_pool_unit.sv
// Self-checking testbench for the software timer pool: directed, rebase and random traffic.
module tb_software_timer_pool_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import stp_pkg::*;

  localparam int POOL_SIZE = 8;
  localparam int STALL_LIMIT = 2000;

  // Command codes the block does not define; they must leave the pool alone.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic                 status;
    logic [HANDLE_W-1:0]  granted;
    logic [ELAPSED_W-1:0] elapsed;
  } timer_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     command = '0;
  logic [HANDLE_W-1:0]  handle = '0;
  logic                 cfg_write = 1'b0;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 done;
  logic                 status;
  logic [HANDLE_W-1:0]  granted_handle;
  logic [ELAPSED_W-1:0] elapsed;

  // Predicted pool state.
  logic [ELAPSED_W-1:0] ticks_now = '0;
  logic [ELAPSED_W-1:0] mark_q[POOL_SIZE];
  logic                 busy_q[POOL_SIZE];
  logic [LIMIT_W-1:0]   limit_now = LIMIT_RESET;

  timer_result_t expected_results[$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  int idle_pct = 0;

  software_timer_pool_unit #(
    .NUM_TIMERS(POOL_SIZE),
    .TICK_BITS (16)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .handle        (handle),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .granted_handle(granted_handle),
    .elapsed       (elapsed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      mark_q[i] = '0;
      busy_q[i] = 1'b0;
    end
  end

  function automatic timer_result_t pool_apply(input logic [CMD_W-1:0] cmd,
                                               input logic [HANDLE_W-1:0] h);
    timer_result_t r;
    r = '0;
    case (cmd)
      CMD_TICK: begin
        ticks_now = ticks_now + 1'b1;
        // The amount taken off is the count itself, which exceeds the limit when the
        // limit was lowered below the running count.
        if (ticks_now >= limit_now) begin
          for (int i = 0; i < POOL_SIZE; i++)
            if (busy_q[i]) mark_q[i] = mark_q[i] - ticks_now;
          ticks_now = '0;
        end
      end
      CMD_ALLOC: begin
        r.status = STATUS_FULL;
        for (int i = 0; i < POOL_SIZE; i++) begin
          if (!busy_q[i] && r.status == STATUS_FULL) begin
            busy_q[i] = 1'b1;
            r.status = STATUS_OK;
            r.granted = HANDLE_W'(i);
          end
        end
      end
      CMD_FREE:  busy_q[h] = 1'b0;
      CMD_RESET: mark_q[h] = ticks_now;
      CMD_GET:   r.elapsed = ticks_now - mark_q[h];
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sends one word, holding it until the block takes it, then records its expected result.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] h);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    handle <= h;
    do @(posedge clk); while (busy);
    expected_results.push_back(pool_apply(cmd, h));
  endtask

  task automatic wait_pool_quiet();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_rebase_limit(input logic [LIMIT_W-1:0] value);
    wait_pool_quiet();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    limit_now = value;
  endtask

  task automatic read_all_timers();
    for (int i = 0; i < POOL_SIZE; i++) issue_command(CMD_GET, HANDLE_W'(i));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ($isunknown(done)) begin
        flag_mismatch("done strobe is unknown");
      end else if (done) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          timer_result_t want;
          want = expected_results.pop_front();
          if (status !== want.status)
            flag_mismatch($sformatf("status %b, expected %b", status, want.status));
          if (granted_handle !== want.granted)
            flag_mismatch($sformatf("granted_handle %0d, expected %0d",
                                    granted_handle, want.granted));
          if (elapsed !== want.elapsed)
            flag_mismatch($sformatf("elapsed %0d, expected %0d", elapsed, want.elapsed));
        end
      end
    end
  end

  // Ends the run if neither a command nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("software_timer_pool_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_directed_commands();
    issue_command(CMD_GET, 3'd0);
    repeat (3) issue_command(CMD_TICK, 3'd0);
    repeat (POOL_SIZE) issue_command(CMD_ALLOC, 3'd0);
    issue_command(CMD_ALLOC, 3'd0);
    issue_command(CMD_RESET, 3'd7);
    issue_command(CMD_GET, 3'd0);
    issue_command(CMD_TICK, 3'd7);
    issue_command(CMD_GET, 3'd7);
    issue_command(CMD_FREE, 3'd3);
    issue_command(CMD_ALLOC, 3'd0);
    // A second free of a timer does nothing; reset and get still act on a timer that is not busy.
    issue_command(CMD_FREE, 3'd5);
    issue_command(CMD_FREE, 3'd5);
    issue_command(CMD_RESET, 3'd5);
    issue_command(CMD_TICK, 3'd0);
    issue_command(CMD_GET, 3'd5);
    issue_command(CMD_SPARE_A, 3'd7);
    issue_command(CMD_SPARE_B, 3'd0);
    issue_command(CMD_SPARE_C, 3'd5);
    issue_command(CMD_GET, 3'd3);
  endtask

  task automatic test_short_limit_rebase();
    write_rebase_limit(16'd40);
    issue_command(CMD_RESET, 3'd2);
    do issue_command(CMD_TICK, 3'd0); while (ticks_now != 0);
    read_all_timers();
  endtask

  task automatic test_limit_extremes();
    write_rebase_limit(16'hFFFF);
    issue_command(CMD_RESET, 3'd1);
    repeat (200) issue_command(CMD_TICK, 3'd0);
    read_all_timers();
    // Lower the limit below the running count: the next tick rebases by the full count.
    repeat (100) issue_command(CMD_TICK, 3'd0);
    issue_command(CMD_RESET, 3'd4);
    write_rebase_limit(16'd10);
    issue_command(CMD_TICK, 3'd0);
    read_all_timers();
    write_rebase_limit(16'd1);
    repeat (3) issue_command(CMD_TICK, 3'd0);
    read_all_timers();
    // With a zero limit every tick rebases and the counter stays at zero.
    write_rebase_limit('0);
    issue_command(CMD_RESET, 3'd6);
    repeat (3) issue_command(CMD_TICK, 3'd0);
    read_all_timers();
  endtask

  task automatic test_random_traffic(input int pct, input int n_items);
    int kind;
    int busy_list[$];
    logic [CMD_W-1:0] cmd;
    logic [HANDLE_W-1:0] h;
    idle_pct = pct;
    for (int k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        if ($urandom_range(4) == 0) write_rebase_limit(LIMIT_W'($urandom_range(16'hFFFF)));
        else write_rebase_limit(LIMIT_W'($urandom_range(24, 1)));
      end
      if ($urandom_range(99) == 0) wait_pool_quiet();
      busy_list = {};
      for (int i = 0; i < POOL_SIZE; i++)
        if (busy_q[i]) busy_list.push_back(i);
      if (busy_list.size() != 0 && $urandom_range(3) != 0)
        h = HANDLE_W'(busy_list[$urandom_range(busy_list.size() - 1)]);
      else
        h = HANDLE_W'($urandom_range(POOL_SIZE - 1));
      kind = $urandom_range(99);
      if (kind < 40) cmd = CMD_TICK;
      else if (kind < 52) cmd = CMD_ALLOC;
      else if (kind < 64) cmd = CMD_FREE;
      else if (kind < 76) cmd = CMD_RESET;
      else if (kind < 94) cmd = CMD_GET;
      else cmd = CMD_W'($urandom_range(CMD_SPARE_C, CMD_SPARE_A));
      issue_command(cmd, h);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 36;
    test_directed_commands();
    test_short_limit_rebase();
    idle_pct = 45;
    test_limit_extremes();
    test_random_traffic(36, 550);
    test_random_traffic(45, 550);
    test_random_traffic(0, 550);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("software_timer_pool_unit test passed");
    end else begin
      $display("software_timer_pool_unit test failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/stp_pkg.sv
sv/software_timer_pool_unit.sv
dv/tb_software_timer_pool_unit.sv
